>>> sv/binary_min_heap_priority_queue_top_assert.svh
// Assertion macros used by the priority queue sequencer.
`ifndef BINARY_MIN_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define BINARY_MIN_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define BMHPQ_ASSERT_IMPLY(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bmhpq: same-cycle check failed");

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define BMHPQ_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bmhpq: next-cycle check failed");

`endif

>>> sv/bmhpq_pkg.sv
// Types, codes and the rank compare of the heap priority queue.
`timescale 1ns / 1ps
`default_nettype none
package bmhpq_pkg;

    // Operation codes carried on s_tuser
    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_EXTRACT = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    // Status codes carried on m_tuser
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [1:0] CLASS_LOWEST = 2'd3;

    // Class first so that the top 34 bits form the rank key
    typedef struct packed {
        logic [1:0]  cls;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] tag;
    } entry_t;

    typedef struct packed {
        logic [1:0] status;
        entry_t     entry;
        logic [7:0] count;
    } result_t;

    // Returned whenever no entry is extracted
    localparam entry_t DEFAULT_ENTRY = '{
        cls:    2'd3,
        year:   12'd2024,
        month:  4'd1,
        day:    5'd1,
        hour:   5'd0,
        minute: 6'd0,
        tag:    16'd0
    };

    // Strict rank compare: lower class, then earlier timestamp
    function automatic logic key_less(entry_t a, entry_t b);
        return {a.cls, a.year, a.month, a.day, a.hour, a.minute} <
               {b.cls, b.year, b.month, b.day, b.hour, b.minute};
    endfunction

endpackage
`default_nettype wire

>>> sv/bmhpq_ram.sv
// Heap entry store: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none
module bmhpq_ram
    import bmhpq_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire entry_t        wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output entry_t             rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered output
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> sv/bmhpq_ctrl.sv
// Sift sequencer: decodes operations and walks the heap through the store.
`timescale 1ns / 1ps
`default_nettype none
`include "binary_min_heap_priority_queue_top_assert.svh"
module bmhpq_ctrl
    import bmhpq_pkg::*;
#(
    parameter int CAPACITY = 128,
    parameter int AW       = 7,
    parameter int CW       = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    // operation in
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [1:0]    in_op,
    input  wire entry_t        in_entry,
    // result out
    output logic               res_valid,
    input  wire logic          res_ready,
    output result_t            res_data,
    // store access
    output logic               mem_we,
    output logic [AW-1:0]      mem_waddr,
    output entry_t             mem_wdata,
    output logic               mem_re,
    output logic [AW-1:0]      mem_raddr,
    input  wire entry_t        mem_rdata
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_UP_CHK  = 4'd1;
    localparam logic [3:0] S_UP_CMP  = 4'd2;
    localparam logic [3:0] S_EX_ROOT = 4'd3;
    localparam logic [3:0] S_EX_LAST = 4'd4;
    localparam logic [3:0] S_EX_LOAD = 4'd5;
    localparam logic [3:0] S_DN_L    = 4'd6;
    localparam logic [3:0] S_DN_LC   = 4'd7;
    localparam logic [3:0] S_DN_RC   = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    localparam int IW = AW + 2;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] pos_reg, pos_next;
    entry_t        move_reg, move_next;
    entry_t        best_reg, best_next;
    logic [AW-1:0] best_idx_reg, best_idx_next;
    logic          best_child_reg, best_child_next;
    logic [1:0]    status_reg, status_next;
    entry_t        out_reg, out_next;

    logic [AW-1:0] parent;
    logic [IW-1:0] lc_idx, rc_idx, n_ext;
    logic          in_fire, full;
    entry_t        fixed_entry;

    // Resolve step shared by both child compares
    logic          resolve;
    entry_t        sel_entry;
    logic [AW-1:0] sel_idx;
    logic          sel_child;
    logic          lc_less, rc_less;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign full     = (count_reg >= CW'(CAPACITY));
    assign parent   = (pos_reg - AW'(1)) >> 1;
    assign lc_idx   = {1'b0, pos_reg, 1'b1};
    assign rc_idx   = {1'b0, pos_reg, 1'b0} + IW'(2);
    assign n_ext    = IW'(count_reg);
    assign lc_less  = key_less(mem_rdata, move_reg);
    assign rc_less  = key_less(mem_rdata, best_reg);

    // Class zero is stored as the lowest class
    always_comb begin
        fixed_entry = in_entry;
        if (in_entry.cls == 2'd0) begin
            fixed_entry.cls = CLASS_LOWEST;
        end
    end

    // Next-state and store access
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        move_next       = move_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        best_child_next = best_child_reg;
        status_next     = status_reg;
        out_next        = out_reg;
        mem_we          = 1'b0;
        mem_waddr       = pos_reg;
        mem_wdata       = move_reg;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        resolve         = 1'b0;
        sel_entry       = move_reg;
        sel_idx         = pos_reg;
        sel_child       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    status_next = ST_OK;
                    out_next    = DEFAULT_ENTRY;
                    state_next  = S_DONE;
                    unique case (in_op)
                        OP_INSERT: begin
                            if (full) begin
                                status_next = ST_FULL;
                            end else begin
                                move_next  = fixed_entry;
                                pos_next   = count_reg[AW-1:0];
                                count_next = count_reg + CW'(1);
                                state_next = S_UP_CHK;
                            end
                        end
                        OP_EXTRACT: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else begin
                                mem_re     = 1'b1;
                                mem_raddr  = '0;
                                state_next = S_EX_ROOT;
                            end
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            // Hole walks up: fetch parent unless at root
            S_UP_CHK: begin
                if (pos_reg == '0) begin
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = parent;
                    state_next = S_UP_CMP;
                end
            end
            // Move parent down while the new entry strictly outranks it
            S_UP_CMP: begin
                mem_we = 1'b1;
                if (key_less(move_reg, mem_rdata)) begin
                    mem_wdata  = mem_rdata;
                    pos_next   = parent;
                    state_next = S_UP_CHK;
                end else begin
                    state_next = S_DONE;
                end
            end
            // Root word is on the read port; hold it and fetch the last entry
            S_EX_ROOT: begin
                out_next   = mem_rdata;
                mem_re     = 1'b1;
                mem_raddr  = AW'(count_reg - CW'(1));
                state_next = S_EX_LAST;
            end
            S_EX_LAST: begin
                state_next = S_EX_LOAD;
            end
            S_EX_LOAD: begin
                move_next  = mem_rdata;
                count_next = count_reg - CW'(1);
                pos_next   = '0;
                state_next = S_DN_L;
            end
            // Fetch left child if present, else settle here
            S_DN_L: begin
                if (lc_idx < n_ext) begin
                    mem_re     = 1'b1;
                    mem_raddr  = lc_idx[AW-1:0];
                    state_next = S_DN_LC;
                end else begin
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DN_LC: begin
                best_next       = lc_less ? mem_rdata : move_reg;
                best_idx_next   = lc_idx[AW-1:0];
                best_child_next = lc_less;
                if (rc_idx < n_ext) begin
                    mem_re     = 1'b1;
                    mem_raddr  = rc_idx[AW-1:0];
                    state_next = S_DN_RC;
                end else begin
                    resolve   = 1'b1;
                    sel_entry = best_next;
                    sel_idx   = best_idx_next;
                    sel_child = lc_less;
                end
            end
            S_DN_RC: begin
                resolve   = 1'b1;
                sel_entry = rc_less ? mem_rdata : best_reg;
                sel_idx   = rc_less ? rc_idx[AW-1:0] : best_idx_reg;
                sel_child = rc_less || best_child_reg;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Pull the winning child up, or drop the moving entry in the hole
        if (resolve) begin
            mem_we = 1'b1;
            if (sel_child) begin
                mem_wdata  = sel_entry;
                pos_next   = sel_idx;
                state_next = S_DN_L;
            end else begin
                state_next = S_DONE;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        pos_reg        <= pos_next;
        move_reg       <= move_next;
        best_reg       <= best_next;
        best_idx_reg   <= best_idx_next;
        best_child_reg <= best_child_next;
        status_reg     <= status_next;
        out_reg        <= out_next;
    end

    assign res_valid       = (state_reg == S_DONE);
    assign res_data.status = status_reg;
    assign res_data.entry  = out_reg;
    assign res_data.count  = 8'(count_reg);

    `BMHPQ_ASSERT_IMPLY(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(CAPACITY))
    `BMHPQ_ASSERT_IMPLY(a_no_write_idle, aclk, aresetn, state_reg == S_IDLE, !mem_we)
    `BMHPQ_ASSERT_IMPLY(a_read_in_heap, aclk, aresetn, mem_re, CW'(mem_raddr) < count_reg)
    `BMHPQ_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, in_fire, state_reg != S_IDLE)

endmodule
`default_nettype wire

>>> sv/bmhpq_out.sv
// Result register: holds one finished word until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none
module bmhpq_out
    import bmhpq_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire result_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    logic    valid_reg;
    result_t data_reg;

    // Free when empty or being drained this cycle
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Load a new word
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

>>> sv/binary_min_heap_priority_queue_top.sv
// Sequence, accepting edge to result word valid: insert steps S_UP_CHK and S_UP_CMP per
//   level climbed until the root or a parent compare ends the climb; extract steps
//   S_EX_ROOT, S_EX_LAST and S_EX_LOAD, then S_DN_L, S_DN_LC and, with a right child,
//   S_DN_RC per level descended; clear and refused ops go straight to S_DONE.
// Throughput: one word at a time, the next taken after the result leaves the sequencer.
// Reset: aresetn synchronous active low empties the heap; store contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module binary_min_heap_priority_queue_top
    import bmhpq_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // class[1:0], year[13:2], month[17:14], day[22:18], hour[27:23],
    // minute[33:28], tag[49:34], zero[55:50]
    input  wire logic [55:0] s_tdata,
    // op[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // class[1:0], year[13:2], month[17:14], day[22:18], hour[27:23],
    // minute[33:28], tag[49:34], entry_count[57:50], zero[63:58]
    output logic [63:0]      m_tdata,
    // status[1:0]
    output logic [1:0]       m_tuser
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    entry_t        in_entry;
    result_t       res_data, out_data;
    logic          res_valid, res_ready;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    entry_t        mem_wdata, mem_rdata;

    // Unpack the input word
    assign in_entry.cls    = s_tdata[1:0];
    assign in_entry.year   = s_tdata[13:2];
    assign in_entry.month  = s_tdata[17:14];
    assign in_entry.day    = s_tdata[22:18];
    assign in_entry.hour   = s_tdata[27:23];
    assign in_entry.minute = s_tdata[33:28];
    assign in_entry.tag    = s_tdata[49:34];

    bmhpq_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_entry  (in_entry),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    bmhpq_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bmhpq_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_data   (res_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    // Pack the result word
    assign m_tdata = {6'd0, out_data.count, out_data.entry.tag, out_data.entry.minute,
                      out_data.entry.hour, out_data.entry.day, out_data.entry.month,
                      out_data.entry.year, out_data.entry.cls};
    assign m_tuser = out_data.status;

endmodule
`default_nettype wire
